// ===== rtl/asdl_pkg.sv =====
package asdl_pkg;

    // Default store depth
    localparam int CAPACITY_DEF = 256;

    // Request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] found_index;
        logic [8:0] element_count;
    } t_res;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;       // capture request, restart scan
        logic       scan;       // issue next read, compare returned entry
        logic       shift;      // issue next read, write returned entry one slot down
        logic       append;     // write value at end, count up
        logic       remove;     // count down
        logic       match_cap;  // latch index of matching entry
        logic       finish;     // register result and strobe it
        logic [1:0] status;     // status code for the result
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] kind;     // captured request kind
        logic       full;     // store at capacity
        logic       match;    // returned entry equals request value
        logic       drained;  // no read in flight and no entries left to read
    } t_sts;

endpackage

// ===== rtl/asdl_ctrl.sv =====
module asdl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  asdl_pkg::t_sts  i_sts,
    output asdl_pkg::t_ctl  o_ctl,
    output logic            o_busy
);

    asdl_pkg::t_state r_state;
    asdl_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asdl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        case (r_state)
            asdl_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = asdl_pkg::S_EXEC;
                end
            end
            asdl_pkg::S_EXEC: begin
                case (i_sts.kind)
                    asdl_pkg::REQ_INSERT: begin
                        o_ctl.finish = 1'b1;
                        if (i_sts.full) begin
                            o_ctl.status = asdl_pkg::ST_FULL;
                        end else begin
                            o_ctl.append = 1'b1;
                            o_ctl.status = asdl_pkg::ST_OK;
                        end
                        n_state = asdl_pkg::S_IDLE;
                    end
                    asdl_pkg::REQ_SEARCH, asdl_pkg::REQ_DELETE: begin
                        n_state = asdl_pkg::S_SCAN;
                    end
                    default: begin
                        // unused kind: report current count, change nothing
                        o_ctl.finish = 1'b1;
                        o_ctl.status = asdl_pkg::ST_OK;
                        n_state      = asdl_pkg::S_IDLE;
                    end
                endcase
            end
            asdl_pkg::S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.match) begin
                    o_ctl.match_cap = 1'b1;
                    if (i_sts.kind == asdl_pkg::REQ_DELETE) begin
                        n_state = asdl_pkg::S_SHIFT;
                    end else begin
                        o_ctl.finish = 1'b1;
                        o_ctl.status = asdl_pkg::ST_OK;
                        n_state      = asdl_pkg::S_IDLE;
                    end
                end else if (i_sts.drained) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.status = asdl_pkg::ST_NOT_FOUND;
                    n_state      = asdl_pkg::S_IDLE;
                end
            end
            asdl_pkg::S_SHIFT: begin
                o_ctl.shift = 1'b1;
                if (i_sts.drained) begin
                    o_ctl.remove = 1'b1;
                    o_ctl.finish = 1'b1;
                    o_ctl.status = asdl_pkg::ST_OK;
                    n_state      = asdl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = asdl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/asdl_dpath.sv =====
module asdl_dpath #(
    parameter int CAPACITY = asdl_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  asdl_pkg::t_req  i_req,
    input  asdl_pkg::t_ctl  i_ctl,
    output asdl_pkg::t_sts  o_sts,
    output logic            o_done,
    output asdl_pkg::t_res  o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry store
    logic [31:0]      r_mem [CAPACITY];

    asdl_pkg::t_req   r_req;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_addr;
    logic             r_pend;
    logic [IW-1:0]    r_pend_idx;
    logic [31:0]      r_rd_data;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    n_idx;
    logic             r_done;
    asdl_pkg::t_res   r_result;

    logic             more;
    logic             rd_go;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [31:0]      wr_data;

    // Read sequencing: one entry per cycle while entries remain
    assign more  = (r_addr < r_count);
    assign rd_go = (i_ctl.scan || i_ctl.shift) && more;

    // Single write port: append at end, or move returned entry down one slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = r_req.value;
        if (i_ctl.append) begin
            wr_en = 1'b1;
        end else if (i_ctl.shift && r_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_idx - 1'b1;
            wr_data = r_rd_data;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_go) begin
            r_rd_data <= r_mem[r_addr[IW-1:0]];
        end
    end

    // Next count and result index
    always_comb begin
        n_count = r_count;
        if (i_ctl.append) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.remove) begin
            n_count = r_count - 1'b1;
        end
        n_idx = r_idx;
        if (i_ctl.load) begin
            n_idx = '0;
        end else if (i_ctl.append) begin
            n_idx = r_count[IW-1:0];
        end else if (i_ctl.match_cap) begin
            n_idx = r_pend_idx;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_ctl.finish;
            if (i_ctl.load) begin
                r_addr <= '0;
                r_pend <= 1'b0;
            end else begin
                r_pend <= rd_go;
                if (rd_go) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
        end
        if (rd_go) begin
            r_pend_idx <= r_addr[IW-1:0];
        end
        r_idx <= n_idx;
        if (i_ctl.finish) begin
            r_result.status        <= i_ctl.status;
            r_result.found_index   <= 8'(n_idx);
            r_result.element_count <= 9'(n_count);
        end
    end

    // Status to controller
    assign o_sts.kind    = r_req.req_type;
    assign o_sts.full    = (r_count == CW'(CAPACITY));
    assign o_sts.match   = r_pend && (r_rd_data == r_req.value);
    assign o_sts.drained = !r_pend && !more;

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/append_search_delete_list.sv =====
// Unsorted list of signed 32-bit values held in an on-chip store with a count.
// Request channel: drive i_req and raise start; the transfer happens at a
// rising edge with start high and busy low. busy stays high until the result
// is out. Kinds: insert appends at the end (status full when at capacity),
// search gives the index of the first equal entry, delete removes the first
// equal entry and moves later entries down one slot.
// Result channel: o_done is high for exactly one cycle with o_result valid;
// the receiver cannot stall it, and the next request may be taken in that
// same cycle.
// Insert and unused kinds need no store read. Search and delete walk the store
// through one read port, one entry per cycle: a search stops at the first hit,
// while a miss and a delete hit read the whole list (scan and shift share the
// same read stream).
// Reset (synchronous, active low) empties the list; stored entries are not
// cleared, since only entries below the count are ever read.
module append_search_delete_list #(
    parameter int CAPACITY = asdl_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  asdl_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_done,
    output asdl_pkg::t_res  o_result
);

    asdl_pkg::t_ctl ctl;
    asdl_pkg::t_sts sts;

    // Sequencer
    asdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // Store, count and result registers
    asdl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // A transfer always starts work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // Result appears exactly as the block returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe out of step with busy");

    // Full and not-found results carry index zero
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == asdl_pkg::ST_FULL ||
                    o_result.status == asdl_pkg::ST_NOT_FOUND))
        |-> (o_result.found_index == 8'd0))
        else $error("nonzero index on a failed request");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import asdl_pkg::*;

    localparam int DEPTH          = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = DEPTH + 16;
    localparam int SEG_MIX        = 150;
    localparam int SEG_FILL       = 330;
    localparam int SEG_DRAIN      = 300;
    localparam int ROUNDS         = 2;

    // request kind the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum int {
        MODE_MIX,
        MODE_FILL,
        MODE_DRAIN
    } t_mode;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_dir_row;

    typedef struct {
        t_res res;
        int   seq;
    } t_pending;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_req  i_req;
    logic  busy;
    logic  o_done;
    t_res  o_result;

    // list model: entries in insertion order plus length
    logic signed [31:0] list_mem [DEPTH];
    int                 list_len;

    t_pending pending_q [$];
    t_pending front_res;
    int       err_cnt;
    int       sent_cnt;
    int       idle_pct;
    int       idle_cycles;

    // directed rows; typed ones carry the result that can be read off by hand
    t_dir_row dir_rows [20] = '{
        '{'{REQ_SEARCH, 32'sd5},        1'b1, '{ST_NOT_FOUND, 8'd0, 9'd0}},
        '{'{REQ_DELETE, 32'sd5},        1'b1, '{ST_NOT_FOUND, 8'd0, 9'd0}},
        '{'{REQ_UNUSED, 32'sd0},        1'b1, '{ST_OK,        8'd0, 9'd0}},
        '{'{REQ_INSERT, 32'h7FFF_FFFF}, 1'b1, '{ST_OK,        8'd0, 9'd1}},
        '{'{REQ_INSERT, 32'h8000_0000}, 1'b1, '{ST_OK,        8'd1, 9'd2}},
        '{'{REQ_INSERT, 32'sd0},        1'b1, '{ST_OK,        8'd2, 9'd3}},
        '{'{REQ_INSERT, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,        8'd3, 9'd4}},
        '{'{REQ_INSERT, 32'h8000_0000}, 1'b1, '{ST_OK,        8'd4, 9'd5}},
        '{'{REQ_SEARCH, 32'h8000_0000}, 1'b1, '{ST_OK,        8'd1, 9'd5}},
        '{'{REQ_SEARCH, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,        8'd3, 9'd5}},
        '{'{REQ_SEARCH, 32'h7FFF_FFFF}, 1'b1, '{ST_OK,        8'd0, 9'd5}},
        '{'{REQ_DELETE, 32'h8000_0000}, 1'b1, '{ST_OK,        8'd1, 9'd4}},
        '{'{REQ_SEARCH, 32'h8000_0000}, 1'b1, '{ST_OK,        8'd3, 9'd4}},
        '{'{REQ_DELETE, 32'h7FFF_FFFF}, 1'b1, '{ST_OK,        8'd0, 9'd3}},
        '{'{REQ_DELETE, 32'h1234_5678}, 1'b1, '{ST_NOT_FOUND, 8'd0, 9'd3}},
        '{'{REQ_UNUSED, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,        8'd0, 9'd3}},
        '{'{REQ_DELETE, 32'h8000_0000}, 1'b1, '{ST_OK,        8'd2, 9'd2}},
        '{'{REQ_SEARCH, 32'sd1},        1'b0, '{ST_OK,        8'd0, 9'd0}},
        '{'{REQ_INSERT, 32'h5555_5555}, 1'b0, '{ST_OK,        8'd0, 9'd0}},
        '{'{REQ_INSERT, 32'hAAAA_AAAA}, 1'b0, '{ST_OK,        8'd0, 9'd0}}
    };

    append_search_delete_list #(
        .CAPACITY(DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // apply one request to the list model and return its result
    function automatic t_res list_apply(t_req r);
        t_res res;
        int   pos;
        res = '{status: ST_OK, found_index: 8'd0, element_count: 9'd0};
        pos = -1;
        // first match wins
        if (r.req_type == REQ_SEARCH || r.req_type == REQ_DELETE) begin
            for (int i = list_len - 1; i >= 0; i--) begin
                if (list_mem[i] == r.value) pos = i;
            end
        end
        case (r.req_type)
            REQ_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    res.found_index    = 8'(list_len);
                    list_mem[list_len] = r.value;
                    list_len++;
                end
            end
            REQ_SEARCH: begin
                if (pos < 0) res.status = ST_NOT_FOUND;
                else res.found_index = 8'(pos);
            end
            REQ_DELETE: begin
                if (pos < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_index = 8'(pos);
                    for (int i = pos; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default: ;
        endcase
        res.element_count = 9'(list_len);
        return res;
    endfunction

    // value for a request: often one already stored, sometimes small or extreme
    function automatic logic signed [31:0] pick_value(bit prefer_stored);
        int roll;
        roll = $urandom_range(0, 99);
        if (prefer_stored && list_len > 0 && roll < 75)
            return list_mem[$urandom_range(0, list_len - 1)];
        if (roll >= 95) return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (roll >= 80) return $signed($urandom_range(0, 7)) - 4;
        return $urandom;
    endfunction

    function automatic t_req random_req(t_mode mode);
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                r.req_type = (roll < 88) ? REQ_INSERT : (roll < 94) ? REQ_SEARCH :
                             (roll < 98) ? REQ_DELETE : REQ_UNUSED;
            end
            MODE_DRAIN: begin
                r.req_type = (roll < 10) ? REQ_INSERT : (roll < 30) ? REQ_SEARCH :
                             (roll < 97) ? REQ_DELETE : REQ_UNUSED;
            end
            default: begin
                r.req_type = (roll < 40) ? REQ_INSERT : (roll < 70) ? REQ_SEARCH :
                             (roll < 97) ? REQ_DELETE : REQ_UNUSED;
            end
        endcase
        r.value = pick_value(r.req_type == REQ_SEARCH || r.req_type == REQ_DELETE);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        err_cnt++;
    endtask

    // drive one request and wait for its transfer; queue what it should produce
    task automatic send_req(t_req r, bit typed, t_res typed_res);
        t_res pred;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = list_apply(r);
        pending_q.push_back('{res: typed ? typed_res : pred, seq: sent_cnt});
        sent_cnt++;
    endtask

    // hold off until every queued result has come back
    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", o_result));
            end else begin
                front_res = pending_q.pop_front();
                if (o_result.status !== front_res.res.status)
                    report_mismatch($sformatf("item %0d status got %0d want %0d",
                        front_res.seq, o_result.status, front_res.res.status));
                if (o_result.found_index !== front_res.res.found_index)
                    report_mismatch($sformatf("item %0d found_index got %0d want %0d",
                        front_res.seq, o_result.found_index, front_res.res.found_index));
                if (o_result.element_count !== front_res.res.element_count)
                    report_mismatch($sformatf("item %0d element_count got %0d want %0d",
                        front_res.seq, o_result.element_count, front_res.res.element_count));
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_mode seg_mode;
        int    seg_len;
        int    rand_total;
        int    rand_idx;

        start       <= 1'b0;
        i_req       <= '0;
        i_rst_n     <= 1'b0;
        idle_cycles = 0;
        err_cnt     = 0;
        sent_cnt    = 0;
        list_len    = 0;
        idle_pct    = 36;
        rand_total  = ROUNDS * (SEG_MIX + SEG_FILL + SEG_DRAIN);
        rand_idx    = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
        wait_results();

        // random part: mixed, fill past full, drain, repeated
        for (int rnd = 0; rnd < ROUNDS * 3; rnd++) begin
            case (rnd % 3)
                0: begin
                    seg_mode = MODE_MIX;
                    seg_len  = SEG_MIX;
                end
                1: begin
                    seg_mode = MODE_FILL;
                    seg_len  = SEG_FILL;
                end
                default: begin
                    seg_mode = MODE_DRAIN;
                    seg_len  = SEG_DRAIN;
                end
            endcase
            for (int n = 0; n < seg_len; n++) begin
                // sender idle rate changes over the run: 36, then 74, then 0 percent
                if (rand_idx < rand_total / 3) idle_pct = 36;
                else if (rand_idx < 2 * rand_total / 3) idle_pct = 74;
                else idle_pct = 0;
                send_req(random_req(seg_mode), 1'b0, '0);
                rand_idx++;
            end
            wait_results();
        end

        // tail: let any stray result show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
